### rtl/core/assert_macros.svh
// Assertion macros for the RTL modules, used by bba_dpath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is held
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check, active during reset too
`define BBA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/bba_pkg.sv
// Shared types and constants of the bitmap block allocator
`default_nettype none
package bba_pkg;

  localparam int BLK_W  = 12;        // block number field
  localparam int TOT_W  = 13;        // managed count register
  localparam int BASE_W = TOT_W + 1; // scan base, may step one word past the count
  localparam int DATA_W = 32;        // config data bus
  localparam int CFG_AW = 3;         // config byte address

  localparam logic [TOT_W-1:0] TOTAL_RST = 13'd4096;

  localparam logic [CFG_AW-3:0] REG_TOTAL = 1'b0;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic             func;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] result_block;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic free_rd;
    logic free_ev;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic req_free;
    logic imm_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/bba_if.sv
// Request and response channel interfaces
`default_nettype none
interface bba_req_if;
  logic          valid;
  logic          ready;
  bba_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bba_rsp_if;
  logic          valid;
  logic          ready;
  bba_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/bba_regs.sv
// Configuration register file behind the APB-style port
`default_nettype none
module bba_regs #(
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bba_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]  pwdata,
  output      logic [bba_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready,
  output      logic [bba_pkg::TOT_W-1:0]   limit
);

  logic [bba_pkg::TOT_W-1:0] total_r;
  logic                      sel_total;

  assign sel_total = (paddr[bba_pkg::CFG_AW-1:2] == bba_pkg::REG_TOTAL);
  assign pready    = 1'b1;
  assign prdata    = sel_total ? bba_pkg::DATA_W'(total_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bba_pkg::TOTAL_RST;
    end else if (psel && penable && pwrite && sel_total) begin
      total_r <= pwdata[bba_pkg::TOT_W-1:0];
    end
  end

  // clamp the count to the store's capacity
  always_comb begin
    if (32'(total_r) > 32'(MAX_BLOCKS)) begin
      limit = bba_pkg::TOT_W'(MAX_BLOCKS);
    end else begin
      limit = total_r;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bba_ctrl.sv
// Sequencer for clear, allocate scan, free and result hand-off
`default_nettype none
module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire bba_pkg::sts_t sts,
  output      bba_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_EV,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.imm_done) begin
            state_nxt = S_EMIT;
          end else if (sts.req_free) begin
            state_nxt = S_FREE_RD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FREE_EV;
      end
      S_FREE_EV: begin
        cmd.free_ev = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bba_dpath.sv
// Bitmap store, word scanner, free path and output register
`default_nettype none
`include "assert_macros.svh"
module bba_dpath #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bba_pkg::cmd_t              cmd,
  output      bba_pkg::sts_t              sts,
  input  wire bba_pkg::req_t              in_data,
  input  wire logic [bba_pkg::TOT_W-1:0]  limit,
  input  wire logic                       out_ready,
  output      logic                       out_valid,
  output      bba_pkg::rsp_t              out_data
);

  localparam int BLK_W     = bba_pkg::BLK_W;
  localparam int BASE_W    = bba_pkg::BASE_W;
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  // word index by reciprocal multiply, exact for every block number
  localparam int QSH       = 2 * BLK_W;
  localparam int RECIP     = (1 << QSH) / WORD_BITS + 1;
  localparam int RW        = $clog2(RECIP + 1);
  localparam int PW        = BLK_W + RW;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  logic [AW-1:0]        addr_r;
  logic [BASE_W-1:0]    base_r;
  logic [BLK_W-1:0]     blk_r;
  logic [BW-1:0]        bitpos_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic [BLK_W-1:0]     res_block_r;
  logic [1:0]           res_status_r;
  logic                 out_valid_r;
  bba_pkg::rsp_t        out_data_r;

  logic [BASE_W-1:0]    limit_ext;
  logic [BASE_W-1:0]    remain;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] free_v;
  logic [WORD_BITS-1:0] lowest;
  logic [BW-1:0]        idx;
  logic                 hit;
  logic                 last_word;
  logic [BASE_W-1:0]    found_blk;
  logic [PW-1:0]        prod;
  logic [AW-1:0]        q;
  logic [BLK_W-1:0]     qw;
  logic [BLK_W-1:0]     rem;
  logic                 blk_oor;
  logic                 is_free;
  logic                 out_load;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] clr_bit;

  assign limit_ext = BASE_W'(limit);
  assign remain    = limit_ext - base_r;

  // find the lowest free block of the word under inspection
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      vmask[i] = (BASE_W'(i) < remain);
    end
    free_v = ~rdata_r & vmask;
    lowest = free_v & (~free_v + 1'b1);
    idx    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | BW'(i);
      end
    end
  end

  assign hit       = |free_v;
  assign last_word = (remain <= BASE_W'(WORD_BITS));
  assign found_blk = base_r + BASE_W'(idx);

  assign prod    = PW'(in_data.block_number) * PW'(RECIP);
  assign q       = AW'(prod[PW-1:QSH]);
  assign qw      = BLK_W'(int'(addr_r) * WORD_BITS);
  assign rem     = blk_r - qw;
  assign clr_bit = WORD_BITS'(1) << bitpos_r;

  assign is_free = (in_data.func == bba_pkg::FUNC_FREE);
  assign blk_oor = ({1'b0, in_data.block_number} >= limit);

  assign sts.clear_done = (addr_r == AW'(MAP_WORDS - 1));
  assign sts.req_free   = is_free;
  assign sts.imm_done   = is_free ? blk_oor : (limit == '0);
  assign sts.scan_done  = hit || last_word;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_load = cmd.emit && sts.out_free;

  always_comb begin
    if (cmd.scan) begin
      rd_addr = addr_r + 1'b1;
    end else if (cmd.accept) begin
      rd_addr = '0;
    end else begin
      rd_addr = addr_r;
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    if (cmd.clear) begin
      we = 1'b1;
    end else if (cmd.scan && hit) begin
      we    = 1'b1;
      wdata = rdata_r | lowest;
    end else if (cmd.free_ev) begin
      we    = 1'b1;
      wdata = rdata_r & ~clr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_r] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        addr_r <= addr_r + 1'b1;
      end else if (cmd.accept) begin
        addr_r <= is_free ? q : '0;
      end else if (cmd.scan && !sts.scan_done) begin
        addr_r <= addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r <= '0;
      blk_r  <= in_data.block_number;
      if (is_free) begin
        res_block_r  <= in_data.block_number;
        res_status_r <= bba_pkg::ST_RANGE;
      end else begin
        res_block_r  <= '0;
        res_status_r <= bba_pkg::ST_FULL;
      end
    end
    if (cmd.scan) begin
      base_r <= base_r + BASE_W'(WORD_BITS);
      if (hit) begin
        res_block_r  <= BLK_W'(found_blk);
        res_status_r <= bba_pkg::ST_OK;
      end else begin
        res_block_r  <= '0;
        res_status_r <= bba_pkg::ST_FULL;
      end
    end
    if (cmd.free_rd) begin
      bitpos_r <= BW'(rem);
    end
    if (cmd.free_ev) begin
      res_block_r  <= blk_r;
      res_status_r <= rdata_r[bitpos_r] ? bba_pkg::ST_OK : bba_pkg::ST_DOUBLE;
    end
    if (out_load) begin
      out_data_r.result_block <= res_block_r;
      out_data_r.status       <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BBA_ASSERT(a_scan_below_limit, clk, rst_n, cmd.scan |-> (base_r < limit_ext), "scan past managed count")
  `BBA_ASSERT(a_bitpos_in_word, clk, rst_n, cmd.free_ev |-> (32'(bitpos_r) < WORD_BITS), "free bit outside word")
  `BBA_ASSERT(a_alloc_one_bit, clk, rst_n, (cmd.scan && hit) |-> $onehot(lowest), "allocate marks other than one bit")

endmodule
`default_nettype wire

### rtl/core/bitmap_block_allocator.sv
// Sequence: an allocate scans the bitmap a word at a time, up to ceil(MAX_BLOCKS / WORD_BITS) words
// (128 at default size); a free in range reads its word in FREE_RD and clears the bit in FREE_EV; a
// free out of range or an allocate with a zero count goes straight to the result hand-off.
// Flow: one request at a time, the next taken the cycle after the result is loaded; a stalled
// output holds the next request off.
// Reset: sync, active low; bitmap cleared word by word, count 4096.
`default_nettype none
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bba_req_if.sink                          in_ch,
  bba_rsp_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bba_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]  pwdata,
  output      logic [bba_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready
);

  bba_pkg::cmd_t             cmd;
  bba_pkg::sts_t             sts;
  logic [bba_pkg::TOT_W-1:0] limit;

  bba_regs #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit   (limit)
  );

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.payload),
    .limit     (limit),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.payload)
  );

endmodule
`default_nettype wire

### test/tb_bitmap_block_allocator.sv
// Testbench for bitmap_block_allocator: directed table, then random traffic checked by a predictor
`timescale 1ns / 1ps
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int BLOCK_CAP = 4096;
  localparam int RANDOM_ITEMS = 1650;
  localparam logic [CFG_AW-1:0] TOTAL_ADDR = {REG_TOTAL, 2'b00};

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             func;
    logic [BLK_W-1:0] block_number;
    logic [BLK_W-1:0] want_block;
    logic [1:0]       want_status;
    logic [31:0]      count_val;
  } step_t;

  localparam int N_ROWS = 28;

  // Walked in order; typed rows carry their result, predict rows go through the predictor, count rows set the count.
  step_t directed_rows [N_ROWS] = '{
    '{ROW_TYPED,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_TYPED,   FUNC_ALLOC, 12'hfff,  12'd1,    ST_OK,     32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd1,    12'd1,    ST_OK,     32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd1,    12'd1,    ST_DOUBLE, 32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd4095, 12'd4095, ST_DOUBLE, 32'd0},
    '{ROW_TYPED,   FUNC_ALLOC, 12'h555,  12'd1,    ST_OK,     32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_PREDICT, FUNC_ALLOC, 12'haaa,  12'd0,    ST_OK,     32'd0},
    '{ROW_COUNT,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_TYPED,   FUNC_ALLOC, 12'd0,    12'd0,    ST_FULL,   32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd0,    12'd0,    ST_RANGE,  32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd4095, 12'd4095, ST_RANGE,  32'd0},
    '{ROW_COUNT,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'hffff_ffff},
    '{ROW_TYPED,   FUNC_FREE,  12'd4095, 12'd4095, ST_DOUBLE, 32'd0},
    '{ROW_PREDICT, FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_COUNT,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd2},
    '{ROW_TYPED,   FUNC_ALLOC, 12'd7,    12'd0,    ST_FULL,   32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd2,    12'd2,    ST_RANGE,  32'd0},
    '{ROW_PREDICT, FUNC_FREE,  12'd1,    12'd0,    ST_OK,     32'd0},
    '{ROW_PREDICT, FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_COUNT,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd1},
    '{ROW_TYPED,   FUNC_FREE,  12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_PREDICT, FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_COUNT,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd4096},
    '{ROW_PREDICT, FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd0},
    '{ROW_TYPED,   FUNC_FREE,  12'd2,    12'd2,    ST_OK,     32'd0},
    '{ROW_COUNT,   FUNC_ALLOC, 12'd0,    12'd0,    ST_OK,     32'd4097},
    '{ROW_PREDICT, FUNC_FREE,  12'd4095, 12'd0,    ST_OK,     32'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();

  bitmap_block_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  bit            in_use [BLOCK_CAP];
  logic [TOT_W-1:0] total_cnt = TOTAL_RST;
  rsp_t          pending_rsp [$];
  int unsigned   mismatches = 0;

  // Pacing controls
  bit            calm = 1'b0;
  bit            stall_go = 1'b0;
  int unsigned   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb_bitmap_block_allocator: done, errors");
    $finish;
  end

  function automatic int unsigned managed_blocks();
    return (total_cnt > BLOCK_CAP) ? BLOCK_CAP : int'(total_cnt);
  endfunction

  // Apply one request to the shadow bitmap and return the result it yields.
  function automatic rsp_t serve_request(req_t r);
    int unsigned lim;
    rsp_t o;
    lim = managed_blocks();
    o.result_block = '0;
    o.status = ST_FULL;
    if (r.func == FUNC_ALLOC) begin
      for (int b = 0; b < lim; b++) begin
        if (!in_use[b]) begin
          in_use[b] = 1'b1;
          o.result_block = 12'(b);
          o.status = ST_OK;
          break;
        end
      end
    end else begin
      o.result_block = r.block_number;
      if (r.block_number >= lim) begin
        o.status = ST_RANGE;
      end else begin
        o.status = in_use[r.block_number] ? ST_OK : ST_DOUBLE;
        in_use[r.block_number] = 1'b0;
      end
    end
    return o;
  endfunction

  // Mostly frees of blocks in use, some near the edge of the count, some anywhere.
  function automatic logic [BLK_W-1:0] pick_free_target();
    int unsigned lim, sel, cand, top;
    lim = managed_blocks();
    sel = $urandom_range(99);
    if (lim != 0 && sel < 60) begin
      for (int t = 0; t < 8; t++) begin
        cand = $urandom_range(lim - 1);
        if (in_use[cand]) return 12'(cand);
      end
      return 12'($urandom_range(lim - 1));
    end else if (sel < 85) begin
      top = lim + lim / 4 + 1;
      if (top > BLOCK_CAP - 1) top = BLOCK_CAP - 1;
      return 12'($urandom_range(top));
    end
    return 12'($urandom_range(BLOCK_CAP - 1));
  endfunction

  task automatic apb_write(input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = TOTAL_ADDR;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    total_cnt = val[TOT_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read_check();
    logic [31:0] want;
    want = 32'(total_cnt);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = TOTAL_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t count readback: expected %0d, got %0d", $realtime, want, prdata);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_count(input logic [31:0] val);
    drain_results();
    apb_write(val);
    apb_read_check();
  endtask

  task automatic sender_gap();
    while (!calm && $urandom_range(99) < 32) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // Offer one beat at a falling edge, hold it until accepted.
  task automatic push_beat(input req_t r, input bit typed, input rsp_t want);
    rsp_t got;
    req_ch.valid = 1'b1;
    req_ch.payload = r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    got = serve_request(r);
    pending_rsp.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_go) begin
      stall_go = 1'b0;
      stall_left = 400;
    end
    if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    rsp_t got, want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected result beat: block %0d status %0d",
                   $realtime, got.result_block, got.status);
      end else begin
        want = pending_rsp.pop_front();
        if (got.result_block !== want.result_block || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t result mismatch: block exp %0d got %0d, status exp %0d got %0d",
                     $realtime, want.result_block, got.result_block, want.status, got.status);
        end
      end
    end
  end

  initial begin
    req_t r;
    rsp_t want;
    int unsigned sent, phase, n_items, alloc_pct, sel;
    logic [TOT_W-1:0] cnt;
    sent = 0;
    phase = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    apb_read_check();

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_COUNT) begin
        set_count(directed_rows[i].count_val);
      end else begin
        r.func = directed_rows[i].func;
        r.block_number = directed_rows[i].block_number;
        want.result_block = directed_rows[i].want_block;
        want.status = directed_rows[i].want_status;
        sender_gap();
        push_beat(r, directed_rows[i].kind == ROW_TYPED, want);
      end
    end

    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(9);
      case (sel)
        0: cnt = '0;
        1: cnt = 13'd1;
        2: cnt = 13'd4096;
        3: cnt = 13'($urandom_range(8191, 4097));
        default: cnt = 13'($urandom_range(200, 2));
      endcase
      set_count({19'($urandom), cnt});
      calm = (phase == 2);
      n_items = $urandom_range(160, 40);
      alloc_pct = $urandom_range(70, 30);
      for (int k = 0; k < n_items; k++) begin
        // Hold the receiver off long enough to back up the block.
        if (phase == 3 && k == 8) stall_go = 1'b1;
        if (phase == 5 && k == n_items / 2) drain_results();
        r.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        r.block_number = (r.func == FUNC_FREE) ? pick_free_target()
                                               : 12'($urandom_range(BLOCK_CAP - 1));
        sender_gap();
        push_beat(r, 1'b0, want);
        sent++;
      end
      calm = 1'b0;
      phase++;
    end

    req_ch.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (pending_rsp.size() != 0)
      $display("%0d expected results never arrived", pending_rsp.size());
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("tb_bitmap_block_allocator: done, clean");
    else
      $display("tb_bitmap_block_allocator: done, errors");
    $finish;
  end

endmodule

### bitmap_block_allocator.f
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_if.sv
rtl/core/bba_regs.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dpath.sv
rtl/core/bitmap_block_allocator.sv
test/tb_bitmap_block_allocator.sv
